[rtl/byte_stuffed_frame_deframer_core_defines.svh]
// ----------------------------------------------------------------------------
// Byte-stuffed frame deframer assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define BYTE_STUFFED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSFD_AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSFD_AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsfd_pkg.sv]
// ----------------------------------------------------------------------------
// Byte-stuffed frame deframer package
// Line codes, widths and the control word of the frame check unit.
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam int BYTE_W                 = 8;
    localparam int COUNT_W                = 6;
    localparam int FRAME_BUFFER_BYTES_DEF = 64;

    localparam logic [BYTE_W-1:0] TAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_KEEP = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_TAG  = 8'h01;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              add_en;
        logic [BYTE_W-1:0] add_val;
        logic              first_en;
        logic [BYTE_W-1:0] first_val;
    } t_chk_ctl;

endpackage

[rtl/bsfd_mem.sv]
// ----------------------------------------------------------------------------
// Frame memory
// Single-port-write, single-port-read byte store with a registered read port.
// ----------------------------------------------------------------------------
module bsfd_mem
    import bsfd_pkg::*;
#(
    parameter int DEPTH = FRAME_BUFFER_BYTES_DEF,
    parameter int AW    = $clog2(FRAME_BUFFER_BYTES_DEF)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bsfd_chk.sv]
// ----------------------------------------------------------------------------
// Frame check unit
// Keeps the running byte sum and the first byte of the open frame and
// reports whether a closing tag would accept the frame.
// ----------------------------------------------------------------------------
module bsfd_chk
    import bsfd_pkg::*;
#(
    parameter int FW = $clog2(FRAME_BUFFER_BYTES_DEF + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_chk_ctl      i_ctl,
    input  logic [FW-1:0] i_fill,
    output logic          o_pass
);

    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_first;
    logic [FW-1:0]     fill_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.add_en) begin
            r_sum <= r_sum + i_ctl.add_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.first_en) begin
            r_first <= i_ctl.first_val;
        end
    end

    assign fill_m2 = i_fill - FW'(2);
    assign o_pass  = (i_fill > FW'(2)) && (r_first == BYTE_W'(fill_m2)) && (r_sum == '0);

endmodule

[rtl/byte_stuffed_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// Byte-stuffed frame deframer core
// Removes escapes from a tag-delimited byte stream, verifies each frame and
// delivers the payload bytes of good frames.
// ----------------------------------------------------------------------------
// While hunting or inside a frame the core takes one received word per cycle.
// Received bytes are written to a frame memory as they arrive, and the length
// byte and checksum are tracked on the fly, so a closing tag is judged in the
// same cycle. After a good frame the input stalls while the payload is read
// back through the single read port of the frame memory, one word per cycle
// while the output does not stall.
// A failed frame and an overflow do not stall the input.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer_core
    import bsfd_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_payload_byte,
    output logic [COUNT_W-1:0] o_payload_count,
    output logic               o_last_byte
);

    localparam int AW = $clog2(FRAME_BUFFER_BYTES);
    localparam int FW = $clog2(FRAME_BUFFER_BYTES + 1);

    t_state              r_state, n_state;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_esc, n_esc;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [AW-1:0]       r_last_addr, n_last_addr;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic                r_out_last, n_out_last;

    logic                in_acc;
    logic                out_free;
    logic                pass;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                rd_en;
    logic [FW-1:0]       fill_p1;
    t_chk_ctl            chk_ctl;

    assign o_in_stall = (r_state == ST_DRAIN);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fill_p1    = r_fill + FW'(1);

    bsfd_mem #(
        .DEPTH (FRAME_BUFFER_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (o_payload_byte)
    );

    bsfd_chk #(
        .FW (FW)
    ) u_chk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (chk_ctl),
        .i_fill (r_fill),
        .o_pass (pass)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_fill      <= '0;
            r_esc       <= 1'b0;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_esc       <= n_esc;
            r_rd_addr   <= n_rd_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_addr <= n_last_addr;
        r_cnt       <= n_cnt;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_esc       = r_esc;
        n_rd_addr   = r_rd_addr;
        n_last_addr = r_last_addr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = AW'(r_fill);
        wr_data     = i_rx_byte;
        rd_en       = 1'b0;
        chk_ctl     = '0;

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_HUNT: begin
                if (in_acc && (i_rx_byte == TAG_BYTE)) begin
                    n_state       = ST_FRAME;
                    n_fill        = '0;
                    n_esc         = 1'b0;
                    chk_ctl.clear = 1'b1;
                end
            end
            ST_FRAME: begin
                if (in_acc) begin
                    if (i_rx_byte == TAG_BYTE) begin
                        n_esc = 1'b0;
                        if (pass) begin
                            n_state     = ST_DRAIN;
                            n_rd_addr   = AW'(1);
                            n_last_addr = AW'(r_fill - FW'(2));
                            n_cnt       = COUNT_W'(r_fill - FW'(2));
                        end else begin
                            n_fill        = '0;
                            chk_ctl.clear = 1'b1;
                        end
                    end else if (r_esc && (r_fill != '0) &&
                                 ((i_rx_byte == ESC_TAG) || (i_rx_byte == ESC_KEEP))) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_fill - FW'(1));
                        wr_data = (i_rx_byte == ESC_TAG) ? TAG_BYTE : ESC_BYTE;
                        n_esc   = 1'b0;
                        chk_ctl.add_en    = (i_rx_byte == ESC_TAG);
                        chk_ctl.add_val   = BYTE_W'(1);
                        chk_ctl.first_en  = (r_fill == FW'(1));
                        chk_ctl.first_val = wr_data;
                    end else begin
                        wr_en  = 1'b1;
                        n_fill = fill_p1;
                        n_esc  = (i_rx_byte == ESC_BYTE);
                        chk_ctl.add_en    = 1'b1;
                        chk_ctl.add_val   = i_rx_byte;
                        chk_ctl.first_en  = (r_fill == '0);
                        chk_ctl.first_val = i_rx_byte;
                        if (fill_p1 == FW'(FRAME_BUFFER_BYTES)) begin
                            n_state = ST_HUNT;
                            n_esc   = 1'b0;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    rd_en       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_count = r_cnt;
                    n_out_last  = (r_rd_addr == r_last_addr);
                    n_rd_addr   = r_rd_addr + AW'(1);
                    if (r_rd_addr == r_last_addr) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_count = r_out_count;
    assign o_last_byte     = r_out_last;

`include "byte_stuffed_frame_deframer_core_defines.svh"

    `BSFD_AST_IMP(a_last_ends_drain, i_clk, i_rst_n, (r_state == ST_DRAIN) && r_out_valid && r_out_last, r_rd_addr == AW'(1), "last word shown while a drain is under way")
    `BSFD_AST_IMP(a_drain_addr, i_clk, i_rst_n, r_state == ST_DRAIN, (r_rd_addr != '0) && (r_rd_addr <= r_last_addr), "drain address out of payload range")
    `BSFD_AST_IMP(a_fill_bound, i_clk, i_rst_n, r_state == ST_FRAME, r_fill < FW'(FRAME_BUFFER_BYTES), "fill count reached buffer size inside a frame")
    `BSFD_AST_IMP(a_esc_context, i_clk, i_rst_n, r_esc, (r_state == ST_FRAME) && (r_fill != '0), "escape pending outside a nonempty frame")
    `BSFD_AST_NEXT(a_drain_continues, i_clk, i_rst_n, r_out_valid && !r_out_last && !i_out_stall, r_out_valid, "gap inside a payload burst")

endmodule

[dv/byte_stuffed_frame_deframer_core_test.sv]
// ----------------------------------------------------------------------------
// Byte-stuffed frame deframer core testbench
// Feeds tagged, escaped line bytes into the core and predicts every payload
// word of each good frame, then checks the output stream word by word. A short
// directed sequence is followed by random frames (good, with a bad checksum,
// with a bad length byte, overflowing, garbled) and noise, while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer_core_test;
    import bsfd_pkg::*;

    localparam int DEPTH      = FRAME_BUFFER_BYTES_DEF;
    localparam int LINE_WORDS = 430;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 120;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_payload_word;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_LEN
    } t_frame_flaw;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_rx_byte = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [BYTE_W-1:0]  o_payload_byte;
    logic [COUNT_W-1:0] o_payload_count;
    logic               o_last_byte;

    logic [BYTE_W-1:0] line_bytes[$];
    t_payload_word     expected_payload[$];
    int                line_count = 0;
    int                fail_count = 0;
    int                cycle_count = 0;

    logic              frame_open = 1'b0;
    int                stored_len = 0;
    logic              esc_seen = 1'b0;
    logic [BYTE_W-1:0] frame_mem[DEPTH];

    int                send_gap = 0;
    int                sent_words = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                holds_done = 0;
    int                results_seen = 0;

    byte_stuffed_frame_deframer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_count (o_payload_count),
        .o_last_byte     (o_last_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void open_frame();
        frame_open = 1'b1;
        stored_len = 0;
        esc_seen   = 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        int                plen;
        int                k;
        t_payload_word     w;
        if (!frame_open) begin
            if (b == TAG_BYTE) begin
                open_frame();
            end
            return;
        end
        if (b == TAG_BYTE) begin
            esc_seen = 1'b0;
            sum = '0;
            for (k = 0; k < stored_len; k++) begin
                sum = sum + frame_mem[k];
            end
            if (stored_len > 2 && int'(frame_mem[0]) == stored_len - 2 && sum == '0) begin
                plen = stored_len - 2;
                for (k = 0; k < plen; k++) begin
                    w.data  = frame_mem[k + 1];
                    w.count = COUNT_W'(plen);
                    w.last  = (k == plen - 1);
                    expected_payload.push_back(w);
                end
                frame_open = 1'b0;
            end else begin
                open_frame();
            end
            return;
        end
        if (esc_seen && stored_len > 0 && (b == ESC_TAG || b == ESC_KEEP)) begin
            frame_mem[stored_len - 1] = (b == ESC_TAG) ? TAG_BYTE : ESC_BYTE;
            esc_seen = 1'b0;
        end else begin
            frame_mem[stored_len] = b;
            stored_len = stored_len + 1;
            esc_seen = (b == ESC_BYTE);
        end
        if (stored_len >= DEPTH) begin
            frame_open = 1'b0;
            esc_seen   = 1'b0;
        end
    endfunction

    function automatic void push_line(input logic [BYTE_W-1:0] b, input bit counted);
        line_bytes.push_back(b);
        if (counted) begin
            line_count++;
        end
    endfunction

    function automatic void push_stuffed(input logic [BYTE_W-1:0] b);
        if (b == TAG_BYTE) begin
            push_line(ESC_BYTE, 1);
            push_line(ESC_TAG, 1);
        end else if (b == ESC_BYTE) begin
            push_line(ESC_BYTE, 1);
            push_line(ESC_KEEP, 1);
        end else begin
            push_line(b, 1);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 11))
            0: begin
                return TAG_BYTE;
            end
            1: begin
                return ESC_BYTE;
            end
            2: begin
                return ESC_KEEP;
            end
            3: begin
                return ESC_TAG;
            end
            4: begin
                return 8'hFF;
            end
            default: begin
                return BYTE_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic void queue_frame(input int plen, input t_frame_flaw flaw);
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] delta;
        int                k;
        body.push_back(BYTE_W'(plen));
        sum = BYTE_W'(plen);
        for (k = 0; k < plen; k++) begin
            b = pick_byte();
            body.push_back(b);
            sum = sum + b;
        end
        body.push_back(BYTE_W'(0) - sum);
        if (flaw == FLAW_SUM) begin
            body[body.size() - 1] = body[body.size() - 1] ^ BYTE_W'($urandom_range(1, 255));
        end else if (flaw == FLAW_LEN) begin
            delta = BYTE_W'($urandom_range(1, 3));
            body[0] = body[0] + delta;
            body[body.size() - 1] = body[body.size() - 1] - delta;
        end
        push_line(TAG_BYTE, 1);
        foreach (body[i]) begin
            push_stuffed(body[i]);
        end
        push_line(TAG_BYTE, 1);
    endfunction

    function automatic void queue_overflow();
        logic [BYTE_W-1:0] b;
        int                n;
        int                k;
        n = $urandom_range(DEPTH, DEPTH + 4);
        push_line(TAG_BYTE, 1);
        for (k = 0; k < n; k++) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == TAG_BYTE || b == ESC_BYTE) begin
                b = 8'h5A;
            end
            push_line(b, 1);
        end
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 8);
        end else if (r < 95) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(41, 61);
    endfunction

    function automatic int pick_idle(input bit idle_free);
        int r;
        if (idle_free) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_rx_byte  <= '0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_rx_byte);
                sent_words++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (line_bytes.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= line_bytes.pop_front();
                    send_gap = pick_idle((sent_words / 40) % 4 == 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_payload_word w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_payload.size() == 0) begin
                    $error("unexpected payload word %h", o_payload_byte);
                    fail_count++;
                end else begin
                    w = expected_payload.pop_front();
                    if (o_payload_byte !== w.data) begin
                        $error("payload_byte: expected %h, got %h", w.data, o_payload_byte);
                        fail_count++;
                    end
                    if (o_payload_count !== w.count) begin
                        $error("payload_count: expected %0d, got %0d", w.count,
                               o_payload_count);
                        fail_count++;
                    end
                    if (o_last_byte !== w.last) begin
                        $error("last_byte: expected %b, got %b", w.last, o_last_byte);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_done < 2 && results_seen >= (holds_done + 1) * 60) begin
                hold_left = HOLD_LEN;
                holds_done++;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_idle((results_seen / 50) % 4 == 2);
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int          r;
        t_frame_flaw flaw;
        int          k;

        // Noise while hunting, then an escape in the first position that
        // resolves and lets a later zero be stored plainly.
        push_line(8'hFF, 0);
        push_line(ESC_BYTE, 0);
        push_line(TAG_BYTE, 1);
        push_line(ESC_BYTE, 1);
        push_line(ESC_KEEP, 1);
        push_line(ESC_KEEP, 1);
        push_line(TAG_BYTE, 1);
        // The failed close above reopened a frame: an empty payload fails too.
        push_line(8'h00, 1);
        push_line(8'h00, 1);
        push_line(TAG_BYTE, 1);
        // A one-byte payload carrying an escaped tag, in the reopened frame.
        push_line(8'h01, 1);
        push_line(ESC_BYTE, 1);
        push_line(ESC_TAG, 1);
        push_line(8'h81, 1);
        push_line(TAG_BYTE, 1);
        // Payload with both byte extremes and an escaped escape.
        push_line(TAG_BYTE, 1);
        push_line(8'h03, 1);
        push_line(8'hFF, 1);
        push_line(8'h00, 1);
        push_line(ESC_BYTE, 1);
        push_line(ESC_KEEP, 1);
        push_line(8'h81, 1);
        push_line(TAG_BYTE, 1);
        // A plain byte after an escape, then a tag right after an escape.
        push_line(TAG_BYTE, 1);
        push_line(ESC_BYTE, 1);
        push_line(8'h55, 1);
        push_line(ESC_BYTE, 1);
        push_line(TAG_BYTE, 1);

        queue_frame(61, FLAW_NONE);
        queue_overflow();
        while (line_count < LINE_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_frame(pick_len(), FLAW_NONE);
            end else if (r < 84) begin
                flaw = (r < 78) ? FLAW_SUM : FLAW_LEN;
                queue_frame(pick_len(), flaw);
            end else if (r < 86) begin
                queue_overflow();
            end else if (r < 93) begin
                for (k = $urandom_range(1, 6); k > 0; k--) begin
                    push_line(pick_byte(), 0);
                end
            end else begin
                push_line(TAG_BYTE, 1);
                for (k = $urandom_range(1, 10); k > 0; k--) begin
                    push_line(pick_byte(), 1);
                end
                push_line(TAG_BYTE, 1);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_bytes.size() > 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        while (expected_payload.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
